>>> hw/rtl/toroidal_life_automaton_macros.svh
// Assertion macros shared by the toroidal life automaton RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef TOROIDAL_LIFE_AUTOMATON_MACROS_SVH
`define TOROIDAL_LIFE_AUTOMATON_MACROS_SVH

// Checked only while out of reset.
`define TLA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every edge, including during reset.
`define TLA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/tla_pkg.sv
// Shared types and constants for the toroidal life automaton.
// No dependencies; imported by the row memory, the top level and both testbench files.
`default_nettype none

package tla_pkg;

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_ADVANCE = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	localparam logic REG_ACTIVE_ROWS = 1'b0;
	localparam logic REG_ACTIVE_COLS = 1'b1;

	localparam logic [6:0] ROWS_RESET = 7'd48;
	localparam logic [7:0] COLS_RESET = 8'd85;
	localparam int unsigned MIN_SIZE = 3;

	// Row memory port control.
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/tla_row_mem.sv
// Row-wide cell memory: one entry per grid row, registered read.
// Per-row valid bits give all-dead after reset and a clear with no pass over the rows. Uses tla_pkg.
`default_nettype none

module tla_row_mem
	import tla_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mem_ctl_t                 ctl,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_s1;
	logic             rvalid_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (ctl.rd) begin
				rvalid_s1 <= valid_q[raddr];
			end
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// A row never written since reset or clear reads as dead.
	assign rdata = rvalid_s1 ? rdata_s1 : '0;

endmodule

`default_nettype wire

>>> hw/rtl/tla_row_next.sv
// Next-generation logic for one grid row under rule B3/S23 with column wrap.
// Pure combinational; no package dependency.
`default_nettype none

module tla_row_next #(
	parameter int unsigned MAX_COLS = 128
) (
	input  logic [MAX_COLS-1:0]           up,
	input  logic [MAX_COLS-1:0]           cur,
	input  logic [MAX_COLS-1:0]           dn,
	input  logic [$clog2(MAX_COLS+1)-1:0] nc,
	output logic [MAX_COLS-1:0]           nxt
);

	localparam int unsigned CAW = $clog2(MAX_COLS);
	localparam int unsigned NCW = $clog2(MAX_COLS + 1);

	logic [CAW-1:0] last_col;
	logic           up_last;
	logic           cur_last;
	logic           dn_last;

	assign last_col = CAW'(nc - NCW'(1));
	assign up_last  = up[last_col];
	assign cur_last = cur[last_col];
	assign dn_last  = dn[last_col];

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
		logic       ul, cl, dl, ur, cr, dr;
		logic [3:0] cnt;
		logic       active;

		if (c == 0) begin : g_left_wrap
			assign ul = up_last;
			assign cl = cur_last;
			assign dl = dn_last;
		end else begin : g_left
			assign ul = up[c-1];
			assign cl = cur[c-1];
			assign dl = dn[c-1];
		end

		if (c == MAX_COLS - 1) begin : g_right_wrap
			assign ur = up[0];
			assign cr = cur[0];
			assign dr = dn[0];
		end else begin : g_right
			logic at_end;
			assign at_end = (last_col == CAW'(c));
			assign ur = at_end ? up[0]  : up[c+1];
			assign cr = at_end ? cur[0] : cur[c+1];
			assign dr = at_end ? dn[0]  : dn[c+1];
		end

		assign cnt = {3'b000, ul} + {3'b000, up[c]} + {3'b000, ur}
		           + {3'b000, cl} + {3'b000, cr}
		           + {3'b000, dl} + {3'b000, dn[c]} + {3'b000, dr};

		// Columns past the size in use keep their value.
		assign active = (CAW'(c) <= last_col);

		assign nxt[c] = !active ? cur[c]
		              : cur[c]  ? ((cnt == 4'd2) || (cnt == 4'd3))
		              :           (cnt == 4'd3);
	end

endmodule

`default_nettype wire

>>> hw/rtl/toroidal_life_automaton.sv
// Toroidal life automaton top level: command stream, size registers, sweep control.
// Depends on tla_pkg, tla_row_mem, tla_row_next and the assertion macro header.
`default_nettype none
`include "toroidal_life_automaton_macros.svh"

// Conway life (B3/S23) on a wrapped grid of up to MAX_ROWS x MAX_COLS cells, of which the
// top-left active_rows x active_cols part is in use (sizes saturate into 3..MAX). The grid
// lives in a single row-wide memory with a registered read; one command word is taken at a
// time and each gives exactly one result word. A cell read or write goes through a row
// read, then a bit read or patch-and-write-back, then the result load; an out-of-range
// index or a clear goes straight to the result load. An advance sweeps the memory one
// row per cycle through a three-row window. Clear and reset empty the grid at once
// through per-row valid bits, so there is no clearing pass. The next command is accepted
// the cycle after the result is loaded, even while that result still waits on
// m_axis_tready.
module toroidal_life_automaton
	import tla_pkg::*;
#(
	parameter int unsigned MAX_ROWS = 64,
	parameter int unsigned MAX_COLS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// command words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // row_index[5:0], col_index[12:6], cell_in[13], zero
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // cell_out[0], generation_count[32:1],
	                                   // index_error[33], zero
);

	localparam int unsigned RAW = $clog2(MAX_ROWS);
	localparam int unsigned CAW = $clog2(MAX_COLS);
	localparam int unsigned NRW = $clog2(MAX_ROWS + 1);
	localparam int unsigned NCW = $clog2(MAX_COLS + 1);
	localparam int unsigned CW  = $clog2(MAX_ROWS + 3);
	localparam int unsigned SRW = (NRW > 7) ? NRW : 7;
	localparam int unsigned SCW = (NCW > 8) ? NCW : 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_ADV,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [6:0]      rows_q;
	logic [7:0]      cols_q;
	func_t           func_q;
	logic [RAW-1:0]  row_q;
	logic [CAW-1:0]  col_q;
	logic            cell_q;
	logic [CW-1:0]   cnt_q;
	logic [MAX_COLS-1:0] win_up_q;
	logic [MAX_COLS-1:0] win_cur_q;
	logic [MAX_COLS-1:0] row0_q;
	logic [31:0]     gen_q;
	logic            res_cell_q;
	logic            res_err_q;
	logic            m_valid_q;
	logic [39:0]     m_data_q;

	logic [SRW-1:0]  rows_x;
	logic [SCW-1:0]  cols_x;
	logic [NRW-1:0]  nr;
	logic [NCW-1:0]  nc;
	logic            in_accept;
	func_t           in_func;
	logic [5:0]      in_row;
	logic [6:0]      in_col;
	logic            in_cell;
	logic            in_err;
	logic            in_rw;
	logic            adv_last;

	mem_ctl_t            mem_ctl;
	logic [RAW-1:0]      mem_raddr;
	logic [RAW-1:0]      mem_waddr;
	logic [MAX_COLS-1:0] mem_wdata;
	logic [MAX_COLS-1:0] mem_rdata;
	logic [MAX_COLS-1:0] cell_row;
	logic [MAX_COLS-1:0] dn_row;
	logic [MAX_COLS-1:0] nxt_row;

	// Saturate the size registers into the supported range.
	assign rows_x = SRW'(rows_q);
	assign cols_x = SCW'(cols_q);

	always_comb begin
		if (rows_x < SRW'(MIN_SIZE)) begin
			nr = NRW'(MIN_SIZE);
		end else if (rows_x > SRW'(MAX_ROWS)) begin
			nr = NRW'(MAX_ROWS);
		end else begin
			nr = rows_x[NRW-1:0];
		end
		if (cols_x < SCW'(MIN_SIZE)) begin
			nc = NCW'(MIN_SIZE);
		end else if (cols_x > SCW'(MAX_COLS)) begin
			nc = NCW'(MAX_COLS);
		end else begin
			nc = cols_x[NCW-1:0];
		end
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign in_func       = func_t'(s_axis_tuser);
	assign in_row        = s_axis_tdata[5:0];
	assign in_col        = s_axis_tdata[12:6];
	assign in_cell       = s_axis_tdata[13];
	assign in_rw         = (in_func == FUNC_WRITE) || (in_func == FUNC_READ);
	assign in_err        = (SRW'(in_row) >= SRW'(nr)) || (SCW'(in_col) >= SCW'(nc));

	// Final sweep step: the row below the last row is the saved old row 0.
	assign adv_last = (cnt_q == CW'(nr) + CW'(2));
	assign dn_row   = adv_last ? row0_q : mem_rdata;

	always_comb begin
		cell_row        = mem_rdata;
		cell_row[col_q] = cell_q;
	end

	tla_row_next #(
		.MAX_COLS(MAX_COLS)
	) u_row_next (
		.up (win_up_q),
		.cur(win_cur_q),
		.dn (dn_row),
		.nc (nc),
		.nxt(nxt_row)
	);

	tla_row_mem #(
		.DEPTH(MAX_ROWS),
		.WIDTH(MAX_COLS)
	) u_row_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mem_ctl),
		.raddr (mem_raddr),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Memory schedule. During a sweep, step t reads row t-1 (row nr-1 first) and
	// writes the new row t-3, so no row is rewritten before its last read.
	always_comb begin
		mem_ctl   = '0;
		mem_raddr = '0;
		mem_waddr = '0;
		mem_wdata = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && in_rw && !in_err) begin
					mem_ctl.rd = 1'b1;
					mem_raddr  = RAW'(in_row);
				end
				if (in_accept && (in_func == FUNC_CLEAR)) begin
					mem_ctl.clr = 1'b1;
				end
			end
			ST_CELL: begin
				if (func_q == FUNC_WRITE) begin
					mem_ctl.wr = 1'b1;
					mem_waddr  = row_q;
					mem_wdata  = cell_row;
				end
			end
			ST_ADV: begin
				if (cnt_q <= CW'(nr)) begin
					mem_ctl.rd = 1'b1;
					mem_raddr  = (cnt_q == '0) ? RAW'(nr - NRW'(1)) : RAW'(cnt_q - CW'(1));
				end
				if (cnt_q >= CW'(3)) begin
					mem_ctl.wr = 1'b1;
					mem_waddr  = RAW'(cnt_q - CW'(3));
					mem_wdata  = nxt_row;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rows_q     <= ROWS_RESET;
			cols_q     <= COLS_RESET;
			func_q     <= FUNC_WRITE;
			row_q      <= '0;
			col_q      <= '0;
			cell_q     <= 1'b0;
			cnt_q      <= '0;
			win_up_q   <= '0;
			win_cur_q  <= '0;
			row0_q     <= '0;
			gen_q      <= '0;
			res_cell_q <= 1'b0;
			res_err_q  <= 1'b0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ACTIVE_ROWS: rows_q <= cfg_data[6:0];
					REG_ACTIVE_COLS: cols_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// Drop the result word once taken, unless a new one loads on this edge.
			if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						func_q     <= in_func;
						row_q      <= RAW'(in_row);
						col_q      <= CAW'(in_col);
						cell_q     <= in_cell;
						cnt_q      <= '0;
						res_cell_q <= 1'b0;
						res_err_q  <= in_rw && in_err;
						if (in_rw && in_err) begin
							state_q <= ST_DONE;
						end else if (in_rw) begin
							state_q <= ST_CELL;
						end else if (in_func == FUNC_CLEAR) begin
							gen_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ADV;
						end
					end
				end
				ST_CELL: begin
					res_cell_q <= (func_q == FUNC_READ) ? mem_rdata[col_q] : 1'b0;
					state_q    <= ST_DONE;
				end
				ST_ADV: begin
					// Slide the three-row window as each old row arrives.
					if ((cnt_q >= CW'(1)) && (cnt_q <= CW'(nr) + CW'(1))) begin
						win_up_q  <= win_cur_q;
						win_cur_q <= mem_rdata;
					end
					if (cnt_q == CW'(2)) begin
						row0_q <= mem_rdata;
					end
					if (adv_last) begin
						gen_q   <= gen_q + 32'd1;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {6'b000000, res_err_q, gen_q, res_cell_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`TLA_ASSERT(a_no_rw_same_row, (mem_ctl.rd && mem_ctl.wr) |-> (mem_raddr != mem_waddr), "row read and write collide")
	`TLA_ASSERT(a_clr_alone, mem_ctl.clr |-> (!mem_ctl.wr && !mem_ctl.rd && state_q == ST_IDLE), "clear overlaps access")
	`TLA_ASSERT(a_sweep_bound, (state_q == ST_ADV) |-> (cnt_q <= CW'(nr) + CW'(2)), "sweep overran rows")
	`TLA_ASSERT(a_clear_zeroes_gen, (in_accept && in_func == FUNC_CLEAR) |=> (gen_q == 32'd0), "clear kept count")
	`TLA_ASSERT_ALWAYS(a_load_when_free, (state_q == ST_DONE && m_valid_q && !m_axis_tready) |=> (m_data_q == $past(m_data_q) || !arst_n), "result overwritten")

endmodule

`default_nettype wire

>>> tb/sv/tla_result_checker.sv
// Result checker for the toroidal life automaton: follows the size, command and result
// channels, keeps its own copy of the board and the generation count, and compares words.
// Depends on tla_pkg for the command codes, register indexes, reset sizes and minimum size.
module tla_result_checker
	import tla_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // row_index[5:0], col_index[12:6], cell_in[13], zero
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,  // cell_out[0], generation_count[32:1], index_error[33]
	output int          mismatches,
	output int          outstanding,
	output int          compared
);

	typedef struct packed {
		logic        cell_out;
		logic [31:0] gen_count;
		logic        index_error;
	} life_result_t;

	life_result_t        expected_results [$];
	life_result_t        want;
	logic [MAX_COLS-1:0] board [MAX_ROWS];
	logic [31:0]         generations;
	logic [6:0]          rows_reg;
	logic [7:0]          cols_reg;

	function automatic int fit_size(int v, int hi);
		if (v < int'(MIN_SIZE)) return int'(MIN_SIZE);
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Count the wrapped neighbors on the old board; cells past the sizes in use stay put.
	task automatic evolve_board(int nr, int nc);
		logic [MAX_COLS-1:0] prior [MAX_ROWS];
		int live;
		prior = board;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				live = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							live += prior[(r + nr + dr) % nr][(c + nc + dc) % nc];
				if (prior[r][c])
					board[r][c] = (live == 2 || live == 3);
				else
					board[r][c] = (live == 3);
			end
		end
		generations = generations + 32'd1;
	endtask

	task automatic predict(func_t f, int row, int col, logic v);
		life_result_t res;
		int nr;
		int nc;
		nr = fit_size(int'(rows_reg), MAX_ROWS);
		nc = fit_size(int'(cols_reg), MAX_COLS);
		res = '0;
		case (f)
			FUNC_WRITE, FUNC_READ: begin
				if (row >= nr || col >= nc)
					res.index_error = 1'b1;
				else if (f == FUNC_WRITE)
					board[row][col] = v;
				else
					res.cell_out = board[row][col];
			end
			FUNC_ADVANCE: evolve_board(nr, nc);
			FUNC_CLEAR: begin
				for (int r = 0; r < MAX_ROWS; r++)
					board[r] = '0;
				generations = '0;
			end
		endcase
		res.gen_count = generations;
		expected_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROWS; r++)
				board[r] = '0;
			generations = '0;
			rows_reg = ROWS_RESET;
			cols_reg = COLS_RESET;
			expected_results.delete();
			mismatches = 0;
			outstanding = 0;
			compared = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ACTIVE_ROWS)
					rows_reg = cfg_data[6:0];
				else
					cols_reg = cfg_data;
			end
			// Check the outgoing word before taking in a new command on the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result word %h with nothing expected",
						m_axis_tdata));
				end else begin
					want = expected_results.pop_front();
					compared++;
					if (m_axis_tdata[0] !== want.cell_out)
						report_mismatch($sformatf("cell_out expected %0d got %0d",
							want.cell_out, m_axis_tdata[0]));
					if (m_axis_tdata[32:1] !== want.gen_count)
						report_mismatch($sformatf("generation_count expected %0d got %0d",
							want.gen_count, m_axis_tdata[32:1]));
					if (m_axis_tdata[33] !== want.index_error)
						report_mismatch($sformatf("index_error expected %0d got %0d",
							want.index_error, m_axis_tdata[33]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict(func_t'(s_axis_tuser), int'(s_axis_tdata[5:0]),
					int'(s_axis_tdata[12:6]), s_axis_tdata[13]);
			outstanding = expected_results.size();
		end
	end

endmodule

>>> tb/sv/tb_toroidal_life_automaton.sv
// Testbench top for the toroidal life automaton: clock, reset, size writes, command
// stimulus and result back-pressure; checking is done by tla_result_checker.
// Depends on tla_pkg, tla_result_checker and the toroidal_life_automaton RTL.
module tb_toroidal_life_automaton;
	import tla_pkg::*;

	localparam int HOLD_OFF       = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 16;
	localparam int PHASE_ITEMS    = 100;
	localparam int SETTLE         = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // row_index[5:0], col_index[12:6], cell_in[13], zero
	logic [1:0]  s_axis_tuser;  // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // cell_out[0], generation_count[32:1], index_error[33]

	int mismatches;
	int outstanding;
	int compared;
	int rows_now = 48;
	int cols_now = 85;
	int commands;
	int advances;
	int settings;
	int hold_requests;
	int holds_done;
	int idle_cycles;
	bit send_burst;
	bit take_burst;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	toroidal_life_automaton DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	tla_result_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.compared     (compared)
	);

	function automatic int fit_size(int v, int hi);
		if (v < int'(MIN_SIZE)) return int'(MIN_SIZE);
		if (v > hi) return hi;
		return v;
	endfunction

	// Call at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_cmd(func_t f, int row, int col, bit v);
		int gap;
		if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tuser = f;
		s_axis_tdata = {2'b00, v, 7'(col), 6'(row)};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		commands++;
		if (f == FUNC_ADVANCE) advances++;
	endtask

	task automatic drain;
		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic set_size(logic idx, logic [7:0] raw);
		cfg_index = idx;
		cfg_data = raw;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == REG_ACTIVE_ROWS)
			rows_now = fit_size(int'(raw[6:0]), 64);
		else
			cols_now = fit_size(int'(raw), 128);
	endtask

	// Sizes change only with nothing in flight.
	task automatic resize(logic [7:0] rows_raw, logic [7:0] cols_raw);
		drain();
		set_size(REG_ACTIVE_ROWS, rows_raw);
		set_size(REG_ACTIVE_COLS, cols_raw);
		settings++;
	endtask

	// Seed a small cluster, let it evolve, then probe around it.
	task automatic seed_and_probe;
		int br;
		int bc;
		int n;
		br = $urandom_range(0, rows_now - 1);
		bc = $urandom_range(0, cols_now - 1);
		n = $urandom_range(1, 8);
		repeat (n)
			send_cmd(FUNC_WRITE, (br + $urandom_range(0, 2)) % rows_now,
				(bc + $urandom_range(0, 2)) % cols_now, $urandom_range(0, 3) != 0);
		n = $urandom_range(1, 3);
		repeat (n) send_cmd(FUNC_ADVANCE, 0, 0, 0);
		n = $urandom_range(1, 6);
		repeat (n)
			send_cmd(FUNC_READ, (br + rows_now - 1 + $urandom_range(0, 4)) % rows_now,
				(bc + cols_now - 1 + $urandom_range(0, 4)) % cols_now, 0);
	endtask

	// Result side: random stalls, bursts of none, and one long hold-off on request.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
			stall = take_burst ? 0 : $urandom_range(0, 16);
			if (holds_done != hold_requests) begin
				stall = HOLD_OFF;
				holds_done++;
			end
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no word moved for %0d cycles, %0d results still due",
			WATCHDOG_LIMIT, outstanding);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int sel;
		int start;
		int pick;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ACTIVE_ROWS;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_WRITE;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset sizes 48 x 85, corners, bad indexes, a blinker across the wrap.
		send_cmd(FUNC_READ, 0, 0, 0);
		send_cmd(FUNC_WRITE, 47, 84, 1);
		send_cmd(FUNC_READ, 47, 84, 0);
		send_cmd(FUNC_WRITE, 48, 0, 1);
		send_cmd(FUNC_WRITE, 0, 85, 1);
		send_cmd(FUNC_READ, 63, 127, 0);
		send_cmd(FUNC_READ, 0, 127, 0);
		send_cmd(FUNC_WRITE, 47, 84, 0);
		send_cmd(FUNC_WRITE, 0, 84, 1);
		send_cmd(FUNC_WRITE, 0, 0, 1);
		send_cmd(FUNC_WRITE, 0, 1, 1);
		send_cmd(FUNC_ADVANCE, 0, 0, 0);
		send_cmd(FUNC_READ, 47, 0, 0);
		send_cmd(FUNC_READ, 1, 0, 0);
		send_cmd(FUNC_READ, 0, 84, 0);
		send_cmd(FUNC_ADVANCE, 0, 0, 0);
		send_cmd(FUNC_READ, 0, 1, 0);
		send_cmd(FUNC_CLEAR, 0, 0, 0);
		send_cmd(FUNC_READ, 0, 0, 0);
		send_cmd(FUNC_WRITE, 10, 60, 1);

		// Sizes below the minimum saturate to 3 x 3: three cells fill it, then all die.
		resize(8'd0, 8'd2);
		send_cmd(FUNC_WRITE, 0, 0, 1);
		send_cmd(FUNC_WRITE, 1, 1, 1);
		send_cmd(FUNC_WRITE, 2, 2, 1);
		send_cmd(FUNC_ADVANCE, 0, 0, 0);
		send_cmd(FUNC_READ, 2, 0, 0);
		send_cmd(FUNC_ADVANCE, 0, 0, 0);
		send_cmd(FUNC_READ, 1, 1, 0);
		send_cmd(FUNC_WRITE, 3, 0, 1);

		// Row data with the top bit set: masked to 64. The cell outside 3 x 3 must survive.
		resize(8'd192, 8'd128);
		send_cmd(FUNC_READ, 10, 60, 0);
		send_cmd(FUNC_READ, 3, 0, 0);
		send_cmd(FUNC_WRITE, 63, 127, 1);
		send_cmd(FUNC_READ, 63, 127, 0);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				sel = (p == 1) ? 2 : (p == 2) ? 1 : $urandom_range(0, 7);
				case (sel)
					0: resize(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
					1: resize({1'($urandom_range(0, 1)), 7'($urandom_range(64, 127))},
						8'($urandom_range(128, 255)));
					2: resize(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
					default: resize(8'($urandom_range(3, 12)), 8'($urandom_range(3, 16)));
				endcase
			end
			start = commands;
			while (commands - start < PHASE_ITEMS) begin
				// Stall the result side once while commands keep coming.
				if (p == 3 && commands - start >= 40 && hold_requests == 0)
					hold_requests = 1;
				pick = $urandom_range(0, 9);
				if (pick < 6)
					seed_and_probe();
				else if (pick < 9)
					send_cmd(func_t'($urandom_range(0, 2)), $urandom_range(0, 63),
						$urandom_range(0, 127), $urandom_range(0, 1));
				else if ($urandom_range(0, 3) == 0)
					send_cmd(FUNC_CLEAR, $urandom_range(0, 63), $urandom_range(0, 127),
						$urandom_range(0, 1));
				else
					send_cmd(FUNC_ADVANCE, 0, 0, 0);
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		$display("run covered %0d commands (%0d advances) over %0d size settings",
			commands, advances, settings + 1);
		$display("%0d result words compared, %0d mismatches", compared, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tla_pkg.sv
hw/rtl/tla_row_mem.sv
hw/rtl/tla_row_next.sv
hw/rtl/toroidal_life_automaton.sv
tb/sv/tla_result_checker.sv
tb/sv/tb_toroidal_life_automaton.sv
